### design/ikm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table of the Ikeda map iterator.
// No dependencies; every other file of the block depends on this package.
package ikm_pkg;

  localparam int FRAC_BITS     = 24;
  localparam int DISCARD_WIDTH = 14;
  localparam int DATA_W        = 32;
  localparam int GAIN_W        = 17;
  localparam int DSTEP_W       = 14;
  localparam int CFG_AW        = 3;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = 17'd58982;
  localparam logic [DSTEP_W-1:0] DSTEP_RST = 14'd10000;

  // register indexes (paddr bit 2)
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_DISC = 1'b1;

  // op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // angle path, Q28 radians
  localparam int ATAN_ITERS = 28;
  localparam int IT_W       = 5;
  localparam int ANG_W      = 33;
  localparam logic signed [ANG_W-1:0] ANG_POINT_FOUR   = 33'sd107374182;
  localparam logic signed [ANG_W-1:0] ANG_NEG_HALF_PI  = -33'sd421657428;
  localparam logic signed [ANG_W-1:0] ANG_PI           = 33'sd843314857;

  // vector and shared multiplier
  localparam int VEC_W = 38;
  localparam int MA_W  = 39;
  localparam int MB_W  = 33;
  localparam int PR_W  = MA_W + MB_W;
  localparam int G_W   = 31;
  localparam int PH_W  = 53;
  localparam logic signed [MB_W-1:0] GAIN_INV_Q30 = 33'sd652032874;

  // squared magnitude and divider
  localparam int SQ_W  = 64;
  localparam int R_W   = 60;
  localparam int Q_W   = 31;
  localparam int REM_W = 61;
  localparam int DEN_W = 61;
  localparam int DCNT_W = 5;
  localparam logic [SQ_W-1:0] SQ_CAP   = 64'h1 << 59;
  localparam logic [58:0]     DIV_NUM  = 59'h6 << 56;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [27:0] atan_q28(input logic [IT_W-1:0] idx);
    logic [27:0] v;
    case (idx)
      5'd0:    v = 28'd210828714;
      5'd1:    v = 28'd124459457;
      5'd2:    v = 28'd65760959;
      5'd3:    v = 28'd33381290;
      5'd4:    v = 28'd16755422;
      5'd5:    v = 28'd8385879;
      5'd6:    v = 28'd4193963;
      5'd7:    v = 28'd2097109;
      5'd8:    v = 28'd1048571;
      5'd9:    v = 28'd524287;
      5'd10:   v = 28'd262144;
      5'd11:   v = 28'd131072;
      5'd12:   v = 28'd65536;
      5'd13:   v = 28'd32768;
      5'd14:   v = 28'd16384;
      5'd15:   v = 28'd8192;
      5'd16:   v = 28'd4096;
      5'd17:   v = 28'd2048;
      5'd18:   v = 28'd1024;
      5'd19:   v = 28'd512;
      5'd20:   v = 28'd256;
      5'd21:   v = 28'd128;
      5'd22:   v = 28'd64;
      5'd23:   v = 28'd32;
      5'd24:   v = 28'd16;
      5'd25:   v = 28'd8;
      5'd26:   v = 28'd4;
      5'd27:   v = 28'd2;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

### design/ikm_in_if.sv
`timescale 1ns / 1ps
// Input channel of the Ikeda map iterator: valid/ready and one item beat.
// Depends on ikm_pkg for field widths.
interface ikm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [ikm_pkg::DATA_W-1:0] start_re;
  logic signed [ikm_pkg::DATA_W-1:0] start_im;

  modport source (output valid, output op, output start_re, output start_im, input ready);
  modport sink   (input valid, input op, input start_re, input start_im, output ready);
endinterface

### design/ikm_out_if.sv
`timescale 1ns / 1ps
// Result channel of the Ikeda map iterator: valid/ready and one point beat.
// Depends on ikm_pkg for field widths.
interface ikm_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [ikm_pkg::DATA_W-1:0] point_re;
  logic signed [ikm_pkg::DATA_W-1:0] point_im;

  modport source (output valid, output point_re, output point_im, input ready);
  modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

### design/ikm_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: floor(6 * 2^56 / den).
// Depends on ikm_pkg for widths and the request/response structs.
module ikm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ikm_pkg::div_req_t req,
  output ikm_pkg::div_rsp_t rsp
);
  import ikm_pkg::*;

  localparam logic [Q_W-1:0] NUM_LO = DIV_NUM[Q_W-1:0];

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [Q_W-1:0]    quot_r;
  logic [REM_W-1:0]  rem_sh;
  logic              fits;
  logic [DCNT_W-1:0] bit_idx;

  always_comb begin
    bit_idx = cnt_r - DCNT_W'(1);
    rem_sh  = {rem_r[REM_W-2:0], NUM_LO[bit_idx]};
    fits    = (rem_sh >= den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= REM_W'(DIV_NUM >> Q_W);
      den_r  <= req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? (rem_sh - den_r) : rem_sh;
      quot_r <= {quot_r[Q_W-2:0], fits};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

### design/ikeda_map_iterator.sv
`timescale 1ns / 1ps
// Ikeda map iterator. A load beat is taken without holding the input off. A step beat
// holds the input off from accept to the next accept while it runs: the squares, the
// serial divider, phase setup and quadrant folding, 28 CORDIC iterations, the gain
// multiply and, once the discard window is spent, the hand-off of a result to the output
// register, longer while that register waits. Synchronous active-low reset restores
// the point and discard counter to zero and the registers to defaults.
module ikeda_map_iterator (
  input  logic                       clk,
  input  logic                       rst_n,
  ikm_in_if.sink                     in_ch,
  ikm_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ikm_pkg::CFG_AW-1:0] paddr,
  input  logic [ikm_pkg::DATA_W-1:0] pwdata,
  output logic [ikm_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ikm_pkg::*;

  localparam int SH      = 2 * FRAC_BITS - 28;
  localparam int SHR     = (SH >= 0) ? SH : 0;
  localparam int SHL     = (SH < 0) ? -SH : 0;
  localparam int SUM_W   = (FRAC_BITS + 3 > 40) ? FRAC_BITS + 3 : 40;
  localparam logic signed [SUM_W-1:0] ONE     = SUM_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'sh7FFFFFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -(SUM_W'(1) << (DATA_W - 1));
  localparam logic [DISCARD_WIDTH-1:0] DISC_CAP = '1;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_RE, S_SQ_IM, S_SUM, S_DIVGO, S_DIV, S_PHASE, S_PRE, S_CORDIC,
    S_MRH, S_MRL, S_MIH, S_MIL, S_FIN, S_OUT
  } state_t;

  state_t                       state_r;
  logic                         out_valid_r;
  logic signed [DATA_W-1:0]     out_re_r;
  logic signed [DATA_W-1:0]     out_im_r;
  logic signed [DATA_W-1:0]     cur_re_r;
  logic signed [DATA_W-1:0]     cur_im_r;
  logic signed [DATA_W-1:0]     res_re_r;
  logic [DISCARD_WIDTH-1:0]     disc_left_r;
  logic [GAIN_W-1:0]            gain_r;
  logic [DSTEP_W-1:0]           dstep_r;
  logic signed [PR_W-1:0]       prod_r;
  logic [SQ_W-1:0]              s_r;
  logic signed [ANG_W-1:0]      phase_r;
  logic signed [VEC_W-1:0]      vx_r;
  logic signed [VEC_W-1:0]      vy_r;
  logic [G_W-1:0]               g_r;
  logic [PH_W-1:0]              ph_r;
  logic [IT_W-1:0]              iter_r;
  logic [1:0]                   pre_cnt_r;

  logic signed [MA_W-1:0]       mul_a;
  logic signed [MB_W-1:0]       mul_b;
  logic signed [PR_W-1:0]       mul_p;
  logic [VEC_W-1:0]             mag_re;
  logic [VEC_W-1:0]             mag_im;
  logic [SQ_W-1:0]              sq_sc;
  logic [R_W-1:0]               sq_r;
  logic [DISCARD_WIDTH-1:0]     disc_load;
  logic                         cfg_wr;
  logic                         out_load;
  div_req_t                     div_req;
  div_rsp_t                     div_rsp;

  function automatic logic [VEC_W-1:0] part_scale(input logic [PH_W-1:0] ph,
                                                  input logic [PH_W-1:0] pl);
    logic [69:0] c;
    c = (70'(ph) << 16) + 70'(pl);
    return c[69:32];
  endfunction

  function automatic logic signed [DATA_W-1:0] fold(input logic neg,
                                                    input logic [VEC_W-1:0] mag,
                                                    input logic add_one);
    logic signed [SUM_W-1:0] v;
    v = SUM_W'(mag);
    if (neg) v = -v;
    if (add_one) v = v + ONE;
    if (v > SAT_MAX) v = SAT_MAX;
    else if (v < SAT_MIN) v = SAT_MIN;
    return v[DATA_W-1:0];
  endfunction

  ikm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    mag_re = vx_r[VEC_W-1] ? VEC_W'(-vx_r) : VEC_W'(vx_r);
    mag_im = vy_r[VEC_W-1] ? VEC_W'(-vy_r) : VEC_W'(vy_r);
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_SQ_RE: begin
        mul_a = MA_W'(cur_re_r);
        mul_b = MB_W'(cur_re_r);
      end
      S_SQ_IM: begin
        mul_a = MA_W'(cur_im_r);
        mul_b = MB_W'(cur_im_r);
      end
      S_DIVGO: begin
        mul_a = MA_W'({1'b0, gain_r});
        mul_b = GAIN_INV_Q30;
      end
      S_MRH: begin
        mul_a = MA_W'({1'b0, mag_re});
        mul_b = MB_W'({1'b0, g_r[G_W-1:16]});
      end
      S_MRL: begin
        mul_a = MA_W'({1'b0, mag_re});
        mul_b = MB_W'({1'b0, g_r[15:0]});
      end
      S_MIH: begin
        mul_a = MA_W'({1'b0, mag_im});
        mul_b = MB_W'({1'b0, g_r[G_W-1:16]});
      end
      S_MIL: begin
        mul_a = MA_W'({1'b0, mag_im});
        mul_b = MB_W'({1'b0, g_r[15:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    if (SH >= 0) begin
      sq_sc = s_r >> SHR;
    end else if (s_r > (SQ_CAP >> SHL)) begin
      sq_sc = SQ_CAP;
    end else begin
      sq_sc = s_r << SHL;
    end
    sq_r = (sq_sc > SQ_CAP) ? R_W'(SQ_CAP) : sq_sc[R_W-1:0];
    div_req.start = (state_r == S_DIVGO);
    div_req.den   = DEN_W'(sq_r) + (DEN_W'(1) << 28);
    disc_load = (32'(dstep_r) > 32'(DISC_CAP)) ? DISC_CAP : DISCARD_WIDTH'(dstep_r);
    cfg_wr = psel && penable && pwrite && pready;
    out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  end

  always_comb begin
    case (paddr[2])
      REG_GAIN: prdata = DATA_W'(gain_r);
      REG_DISC: prdata = DATA_W'(dstep_r);
      default:  prdata = '0;
    endcase
  end

  assign pready          = 1'b1;
  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.point_re = out_re_r;
  assign out_ch.point_im = out_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cur_re_r    <= '0;
      cur_im_r    <= '0;
      disc_left_r <= '0;
      gain_r      <= GAIN_RST;
      dstep_r     <= DSTEP_RST;
      iter_r      <= '0;
      pre_cnt_r   <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_GAIN: gain_r  <= pwdata[GAIN_W-1:0];
          REG_DISC: dstep_r <= pwdata[DSTEP_W-1:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.op == OP_STEP) begin
              state_r <= S_SQ_RE;
            end else begin
              cur_re_r    <= in_ch.start_re;
              cur_im_r    <= in_ch.start_im;
              disc_left_r <= disc_load;
            end
          end
        end
        S_SQ_RE: begin
          prod_r  <= mul_p;
          state_r <= S_SQ_IM;
        end
        S_SQ_IM: begin
          prod_r  <= mul_p;
          s_r     <= prod_r[SQ_W-1:0];
          state_r <= S_SUM;
        end
        S_SUM: begin
          s_r     <= s_r + prod_r[SQ_W-1:0];
          state_r <= S_DIVGO;
        end
        S_DIVGO: begin
          prod_r  <= mul_p;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) state_r <= S_PHASE;
        end
        S_PHASE: begin
          phase_r   <= ANG_POINT_FOUR - $signed({2'b00, div_rsp.quot});
          vx_r      <= VEC_W'(cur_re_r) <<< 2;
          vy_r      <= VEC_W'(cur_im_r) <<< 2;
          g_r       <= prod_r[G_W+15:16];
          pre_cnt_r <= '0;
          state_r   <= S_PRE;
        end
        S_PRE: begin
          if (phase_r < ANG_NEG_HALF_PI) begin
            phase_r <= phase_r + ANG_PI;
            vx_r    <= -vx_r;
            vy_r    <= -vy_r;
            if (pre_cnt_r == 2'd3) begin
              iter_r  <= '0;
              state_r <= S_CORDIC;
            end else begin
              pre_cnt_r <= pre_cnt_r + 2'd1;
            end
          end else begin
            iter_r  <= '0;
            state_r <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (!phase_r[ANG_W-1]) begin
            vx_r    <= vx_r - (vy_r >>> iter_r);
            vy_r    <= vy_r + (vx_r >>> iter_r);
            phase_r <= phase_r - $signed(ANG_W'(atan_q28(iter_r)));
          end else begin
            vx_r    <= vx_r + (vy_r >>> iter_r);
            vy_r    <= vy_r - (vx_r >>> iter_r);
            phase_r <= phase_r + $signed(ANG_W'(atan_q28(iter_r)));
          end
          if (iter_r == IT_W'(ATAN_ITERS - 1)) begin
            state_r <= S_MRH;
          end else begin
            iter_r <= iter_r + IT_W'(1);
          end
        end
        S_MRH: begin
          prod_r  <= mul_p;
          state_r <= S_MRL;
        end
        S_MRL: begin
          ph_r    <= prod_r[PH_W-1:0];
          prod_r  <= mul_p;
          state_r <= S_MIH;
        end
        S_MIH: begin
          res_re_r <= fold(vx_r[VEC_W-1], part_scale(ph_r, prod_r[PH_W-1:0]), 1'b1);
          prod_r   <= mul_p;
          state_r  <= S_MIL;
        end
        S_MIL: begin
          ph_r    <= prod_r[PH_W-1:0];
          prod_r  <= mul_p;
          state_r <= S_FIN;
        end
        S_FIN: begin
          cur_re_r <= res_re_r;
          cur_im_r <= fold(vy_r[VEC_W-1], part_scale(ph_r, prod_r[PH_W-1:0]), 1'b0);
          if (disc_left_r != '0) begin
            disc_left_r <= disc_left_r - DISCARD_WIDTH'(1);
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_re_r <= cur_re_r;
            out_im_r <= cur_im_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !div_rsp.busy)
    else $error("divider busy while taking a beat");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORDIC) |-> (iter_r < IT_W'(ATAN_ITERS)))
    else $error("CORDIC iteration count out of range");

  a_emit_window: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (disc_left_r == '0))
    else $error("result emitted inside discard window");

endmodule

### test/tb_ikeda_map_iterator.sv
`timescale 1ns / 1ps
// Self-checking testbench of ikeda_map_iterator: load and step beats with random gaps,
// an APB-style register port and a scoreboard that predicts every emitted point.
// Depends on ikm_pkg, ikm_in_if, ikm_out_if and the block itself.
module tb_ikeda_map_iterator;
  import ikm_pkg::*;

  localparam int WATCH_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 200;
  localparam int HOLD_LEN    = 1500;

  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } point_t;

  class ikeda_scoreboard;
    longint      cur_re, cur_im;
    int unsigned left;
    logic [GAIN_W-1:0]  gain;
    logic [DSTEP_W-1:0] dsteps;
    longint      atan_q[ATAN_ITERS];
    point_t      due_points[$];

    function new();
      longint sum, term;
      atan_q[0] = 210828714;
      for (int i = 1; i < ATAN_ITERS; i++) begin
        sum = 0;
        for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
          term = longint'((64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1));
          sum = (k % 2) ? sum - term : sum + term;
        end
        atan_q[i] = (sum + 64'sd2147483648) >>> 32;
      end
      cur_re = 0;
      cur_im = 0;
      left = 0;
      gain = GAIN_RST;
      dsteps = DSTEP_RST;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint scale(longint v, longint unsigned g);
      longint unsigned m, ph, pl, r;
      m = (v < 0) ? longint'(-v) : longint'(v);
      ph = m * (g >> 16);
      pl = m * (g & 64'hFFFF);
      r = (ph >> 16) + ((((ph & 64'hFFFF) << 16) + pl) >> 32);
      return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function void iterate();
      longint unsigned s, r, d, g;
      longint ang, vx, vy, dx, dy;
      s = longint'(cur_re * cur_re) + longint'(cur_im * cur_im);
      r = s >> (2 * FRAC_BITS - 28);
      if (r > (64'd1 << 59)) r = 64'd1 << 59;
      d = r + (64'd1 << 28);
      ang = 64'sd107374182 - longint'((64'd6 << 56) / d);
      vx = cur_re * 4;
      vy = cur_im * 4;
      for (int i = 0; i < 4 && ang < -64'sd421657428; i++) begin
        ang += 64'sd843314857;
        vx = -vx;
        vy = -vy;
      end
      for (int i = 0; i < ATAN_ITERS; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (ang >= 0) begin
          vx -= dx; vy += dy; ang -= atan_q[i];
        end else begin
          vx += dx; vy -= dy; ang += atan_q[i];
        end
      end
      g = (longint'(gain) * 64'd652032874) >> 16;
      cur_re = clamp32(scale(vx, g) + (64'sd1 << FRAC_BITS));
      cur_im = clamp32(scale(vy, g));
    endfunction

    function void note_beat(logic op, logic signed [DATA_W-1:0] re,
                            logic signed [DATA_W-1:0] im);
      point_t p;
      if (op == OP_LOAD) begin
        cur_re = re;
        cur_im = im;
        left = dsteps;
      end else begin
        iterate();
        if (left > 0) begin
          left--;
        end else begin
          p.re = cur_re[DATA_W-1:0];
          p.im = cur_im[DATA_W-1:0];
          due_points.push_back(p);
        end
      end
    endfunction

    function bit check_beat(logic signed [DATA_W-1:0] re, logic signed [DATA_W-1:0] im,
                            output string msg);
      point_t p;
      if (due_points.size() == 0) begin
        msg = $sformatf("unexpected point re=%0d im=%0d", re, im);
        return 0;
      end
      p = due_points.pop_front();
      if (re !== p.re || im !== p.im) begin
        msg = $sformatf("point re=%0d im=%0d, predicted re=%0d im=%0d", re, im, p.re, p.im);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;

  ikm_in_if  in_if ();
  ikm_out_if out_if ();

  ikeda_map_iterator u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ikeda_scoreboard sb;
  int errors, n_loads, n_steps, n_points;
  bit hold_req;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic write_reg(logic idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_GAIN) sb.gain = value[GAIN_W-1:0];
    else sb.dsteps = value[DSTEP_W-1:0];
  endtask

  task automatic send_beat(logic op, logic signed [DATA_W-1:0] re,
                           logic signed [DATA_W-1:0] im);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.start_re <= re;
    in_if.start_im <= im;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_beat(op, re, im);
    if (op == OP_LOAD) n_loads++;
    else n_steps++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_part();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  always begin : result_sink
    int stall;
    string msg;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 15);
      if (hold_req) begin
        stall = HOLD_LEN;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      n_points++;
      if (!sb.check_beat(out_if.point_re, out_if.point_im, msg)) report(msg);
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int n;
    logic [GAIN_W-1:0] g;
    logic [DSTEP_W-1:0] dsc;
    sb = new();
    errors = 0;
    n_loads = 0;
    n_steps = 0;
    n_points = 0;
    hold_req = 1'b0;
    no_gaps = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.op = OP_LOAD;
    in_if.start_re = '0;
    in_if.start_im = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: step from reset point, field extremes, gain extremes
    write_reg(REG_DISC, 32'd0);
    send_beat(OP_STEP, 0, 0);
    send_beat(OP_STEP, 0, 0);
    send_beat(OP_LOAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_beat(OP_STEP, 0, 0);
    send_beat(OP_LOAD, 32'sh8000_0000, 32'sh8000_0000);
    send_beat(OP_STEP, 0, 0);
    send_beat(OP_LOAD, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_beat(OP_STEP, 0, 0);
    send_beat(OP_LOAD, 32'sh0100_0000, 32'sh0);
    send_beat(OP_STEP, 0, 0);
    send_beat(OP_STEP, 0, 0);
    settle();
    write_reg(REG_GAIN, 32'd131071);
    send_beat(OP_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000);
    repeat (4) send_beat(OP_STEP, 0, 0);
    settle();
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_DISC, 32'd2);
    send_beat(OP_LOAD, 32'sh0123_4567, -32'sh0123_4567);
    repeat (4) send_beat(OP_STEP, 0, 0);
    settle();
    // largest window is armed but never reloaded, so it stays harmless
    write_reg(REG_DISC, 32'd16383);
    send_beat(OP_STEP, 0, 0);
    settle();

    // random phases: register setting, then load-and-step runs
    for (int ph = 0; n_loads + n_steps < 1950; ph++) begin
      case (ph % 4)
        0: g = GAIN_RST;
        1: g = 17'd131071;
        2: g = 17'd0;
        default: g = GAIN_W'($urandom);
      endcase
      dsc = (ph % 3 == 0) ? 14'd0 : 14'($urandom_range(1, 6));
      write_reg(REG_GAIN, 32'(g));
      write_reg(REG_DISC, 32'(dsc));
      no_gaps = (ph % 5 == 4);
      for (int b = 0; b < 6; b++) begin
        if (ph == 3 && b == 1) hold_req = 1'b1;
        if ($urandom_range(0, 9) != 0) send_beat(OP_LOAD, rand_part(), rand_part());
        n = $urandom_range(3, 30);
        repeat (n) send_beat(OP_STEP, $urandom, $urandom);
      end
      no_gaps = 1'b0;
      settle();
    end

    $display("ran %0d loads and %0d steps, %0d points checked", n_loads, n_steps, n_points);
    $display("gain covered 0, default, max and random; discard windows 0 to 6");
    if (errors == 0 && sb.due_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
